@@ hw/rtl/wsa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsa_pkg
// Shared sizes, register indexes, command and error codes of the weight slot
// allocator.
// ----------------------------------------------------------------------------
package wsa_pkg;

	localparam int NUM_ARRAYS_DEF = 4;
	localparam int MAX_SLOTS_DEF  = 8;
	localparam int NUM_TOKENS_DEF = 32;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_ARRAYS_IN_USE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLOTS_PER_ARRAY = 2'd1;

	localparam logic [2:0] ARRAYS_IN_USE_RST   = 3'd4;
	localparam logic [3:0] SLOTS_PER_ARRAY_RST = 4'd8;

	localparam logic CMD_ALLOC   = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	localparam logic [1:0] ERR_NONE       = 2'd0;
	localparam logic [1:0] ERR_ZERO_COUNT = 2'd1;
	localparam logic [1:0] ERR_BAD_TOKEN  = 2'd2;

	localparam int FREE_TOTAL_MAX = 63;

endpackage

@@ hw/rtl/wsa_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsa_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module wsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ hw/rtl/weight_slot_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weight_slot_allocator
// Round-robin allocator of weight-buffer slots over a set of compute arrays,
// with a token table held in a synchronous RAM.
// ----------------------------------------------------------------------------
// Flow: an accepted word passes through a work state (ST_ALLOC or ST_REL), then
// ST_DONE, which loads the output register once that is free or being emptied;
// a rejected word goes straight to ST_DONE. No new word is taken until the
// result has been loaded. In ST_ALLOC a stale pointer adds reduction steps and
// each 32-token group past the first adds a scan step.
// Reset: arst_n clears slot counts, token valid bits and pointer; four by eight.
module weight_slot_allocator #(
	parameter int NUM_ARRAYS = wsa_pkg::NUM_ARRAYS_DEF,
	parameter int MAX_SLOTS  = wsa_pkg::MAX_SLOTS_DEF,
	parameter int NUM_TOKENS = wsa_pkg::NUM_TOKENS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,

	// Configuration write channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [wsa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wsa_pkg::CFG_DATA_W-1:0] cfg_data,

	// Request channel
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           command,
	input  logic [7:0]                     consumer_count,
	input  logic [4:0]                     token_index,

	// Result channel
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           granted,
	output logic [1:0]                     array_index,
	output logic [4:0]                     token_given,
	output logic                           slot_freed,
	output logic [5:0]                     free_slots_total,
	output logic [1:0]                     error_code
);

	// Index widths of the arrays, the tokens and the slot counters.
	localparam int AW  = (NUM_ARRAYS > 1) ? $clog2(NUM_ARRAYS) : 1;
	localparam int TW  = (NUM_TOKENS > 1) ? $clog2(NUM_TOKENS) : 1;
	localparam int UW  = $clog2(MAX_SLOTS + 1);
	// The free-token search looks at one group of up to 32 valid bits a cycle.
	localparam int GW   = (NUM_TOKENS < 32) ? NUM_TOKENS : 32;
	localparam int NG   = (NUM_TOKENS + GW - 1) / GW;
	localparam int GIW  = (NG > 1) ? $clog2(NG) : 1;
	localparam int OW   = (GW > 1) ? $clog2(GW) : 1;
	localparam int PADW = NG * GW;
	// A token RAM word holds the consumer count above the array index.
	localparam int RW  = 8 + AW;
	// Compare widths.
	localparam int CW  = (UW > 4) ? UW : 4;
	localparam int NW  = ((AW > 3) ? AW : 3) + 1;
	localparam int IW  = (TW > 5) ? TW : 5;
	localparam int AXW = (AW > 2) ? AW : 2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ALLOC,
		ST_REL,
		ST_DONE
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [2:0] arrays_in_use_q;
	logic [3:0] slots_per_array_q;

	// Allocator state: slot counts and token valid bits stay in flops, the
	// count and array of each token live in the RAM.
	logic [UW-1:0]         slots_used_q [NUM_ARRAYS];
	logic [NUM_TOKENS-1:0] token_valid_q;
	logic [AW-1:0]         rr_q;

	// The word being worked on.
	logic [7:0]    count_q;
	logic [TW-1:0] tok_q;
	logic [AW-1:0] start_q;
	logic [GIW-1:0] grp_q;

	// The result waiting for the output register.
	logic          res_granted_q;
	logic [AW-1:0] res_arr_q;
	logic [TW-1:0] res_tok_q;
	logic          res_freed_q;
	logic [1:0]    res_err_q;

	// Output register.
	logic       out_valid_q;
	logic       granted_q;
	logic [1:0] array_index_q;
	logic [4:0] token_given_q;
	logic       slot_freed_q;
	logic [5:0] free_slots_total_q;
	logic [1:0] error_code_q;

	// Token RAM port signals.
	logic          ram_wr_en;
	logic [TW-1:0] ram_wr_addr;
	logic [RW-1:0] ram_wr_data;
	logic          ram_rd_en;
	logic [TW-1:0] ram_rd_addr;
	logic [RW-1:0] ram_rd_data;

	// ------------------------------------------------------------------------
	// Effective sizes. A zero register counts as one, and both are clipped to
	// what the hardware was built for.
	// ------------------------------------------------------------------------
	logic [2:0] n_act;
	logic [3:0] d_act;

	always_comb begin
		n_act = arrays_in_use_q;
		if (n_act == 3'd0) begin
			n_act = 3'd1;
		end
		if (32'(n_act) > NUM_ARRAYS) begin
			n_act = 3'(NUM_ARRAYS);
		end
		d_act = slots_per_array_q;
		if (d_act == 4'd0) begin
			d_act = 4'd1;
		end
		if (32'(d_act) > MAX_SLOTS) begin
			d_act = 4'(MAX_SLOTS);
		end
	end

	// ------------------------------------------------------------------------
	// Round-robin array search. The start point must already be below the
	// active count; candidates wrap once at most.
	// ------------------------------------------------------------------------
	logic [NUM_ARRAYS-1:0] avail;
	logic                  start_ok;
	logic                  pick_found;
	logic [AW-1:0]         pick;
	logic [NW-1:0]         cand;
	logic [NW-1:0]         rr_next_w;
	logic [AW-1:0]         rr_next;

	always_comb begin
		for (int i = 0; i < NUM_ARRAYS; i++) begin
			avail[i] = CW'(slots_used_q[i]) < CW'(d_act);
		end
		start_ok   = NW'(start_q) < NW'(n_act);
		pick_found = 1'b0;
		pick       = '0;
		cand       = '0;
		for (int i = 0; i < NUM_ARRAYS; i++) begin
			cand = NW'(start_q) + NW'(i);
			if (cand >= NW'(n_act)) begin
				cand = cand - NW'(n_act);
			end
			if (!pick_found && (NW'(i) < NW'(n_act)) && avail[cand[AW-1:0]]) begin
				pick_found = 1'b1;
				pick       = cand[AW-1:0];
			end
		end
		rr_next_w = NW'(pick) + NW'(1);
		if (rr_next_w == NW'(n_act)) begin
			rr_next = '0;
		end else begin
			rr_next = rr_next_w[AW-1:0];
		end
	end

	// ------------------------------------------------------------------------
	// Lowest free token, one group of valid bits per cycle. Padding bits past
	// the last token read as taken.
	// ------------------------------------------------------------------------
	logic [PADW-1:0] valid_pad;
	logic [GW-1:0]   grp_bits;
	logic            tok_hit;
	logic [OW-1:0]   tok_off;
	logic [TW-1:0]   free_tok;
	logic            grp_last;

	always_comb begin
		valid_pad                 = '1;
		valid_pad[NUM_TOKENS-1:0] = token_valid_q;
		grp_bits = valid_pad[int'(grp_q) * GW +: GW];
		tok_hit  = 1'b0;
		tok_off  = '0;
		for (int j = GW - 1; j >= 0; j--) begin
			if (!grp_bits[j]) begin
				tok_hit = 1'b1;
				tok_off = OW'(j);
			end
		end
		free_tok = TW'(int'(grp_q) * GW + int'(tok_off));
		grp_last = (int'(grp_q) == NG - 1);
	end

	// ------------------------------------------------------------------------
	// Release lookup of the incoming word and the RAM read data.
	// ------------------------------------------------------------------------
	logic [IW-1:0] tok_in_ext;
	logic [TW-1:0] tok_in;
	logic          tok_in_ok;
	logic [7:0]    rel_count;
	logic [7:0]    rel_count_next;
	logic [AW-1:0] rel_arr;

	always_comb begin
		tok_in_ext     = IW'(token_index);
		tok_in         = tok_in_ext[TW-1:0];
		tok_in_ok      = (32'(token_index) < NUM_TOKENS) && token_valid_q[tok_in];
		rel_count      = ram_rd_data[RW-1:AW];
		rel_arr        = ram_rd_data[AW-1:0];
		// A valid token always holds a count of at least one.
		rel_count_next = rel_count - 8'd1;
	end

	// ------------------------------------------------------------------------
	// Free slots over the active arrays, read when the result is loaded.
	// ------------------------------------------------------------------------
	logic [7:0] free_sum;
	logic [5:0] free_sat;

	always_comb begin
		free_sum = '0;
		for (int i = 0; i < NUM_ARRAYS; i++) begin
			if ((3'(i) < n_act) && (i < 8) && avail[i]) begin
				free_sum = free_sum + 8'(d_act) - 8'(slots_used_q[i]);
			end
		end
		if (32'(free_sum) > wsa_pkg::FREE_TOTAL_MAX) begin
			free_sat = 6'(wsa_pkg::FREE_TOTAL_MAX);
		end else begin
			free_sat = free_sum[5:0];
		end
	end

	// ------------------------------------------------------------------------
	// Token RAM: read on accept of a release, written back from the ST_REL state
	// that follows; an allocate writes the new entry. Only one word is in flight,
	// so a write never meets a read of the same entry.
	// ------------------------------------------------------------------------
	logic alloc_fire;

	always_comb begin
		alloc_fire  = (state_q == ST_ALLOC) && start_ok && pick_found && tok_hit;
		ram_rd_en   = (state_q == ST_IDLE) && in_valid && (command == wsa_pkg::CMD_RELEASE);
		ram_rd_addr = tok_in;
		ram_wr_en   = alloc_fire || (state_q == ST_REL);
		if (state_q == ST_ALLOC) begin
			ram_wr_addr = free_tok;
			ram_wr_data = {count_q, pick};
		end else begin
			ram_wr_addr = tok_q;
			ram_wr_data = {rel_count_next, rel_arr};
		end
	end

	wsa_ram #(
		.WIDTH (RW),
		.DEPTH (NUM_TOKENS)
	) u_token_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// Output-side widening of indexes to the port widths.
	logic [AXW-1:0] arr_out_ext;
	logic [IW-1:0]  tok_out_ext;

	assign arr_out_ext = AXW'(res_arr_q);
	assign tok_out_ext = IW'(res_tok_q);

	// The finished result moves into the output register once that is free
	// or is being emptied in the same cycle.
	logic load_out;

	assign load_out = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// ------------------------------------------------------------------------
	// Sequencer. Configuration writes are taken in any state; the user must send
	// them only while the block is idle, as the block itself does not enforce it.
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q            <= ST_IDLE;
			arrays_in_use_q    <= wsa_pkg::ARRAYS_IN_USE_RST;
			slots_per_array_q  <= wsa_pkg::SLOTS_PER_ARRAY_RST;
			for (int i = 0; i < NUM_ARRAYS; i++) begin
				slots_used_q[i] <= '0;
			end
			token_valid_q      <= '0;
			rr_q               <= '0;
			count_q            <= '0;
			tok_q              <= '0;
			start_q            <= '0;
			grp_q              <= '0;
			res_granted_q      <= 1'b0;
			res_arr_q          <= '0;
			res_tok_q          <= '0;
			res_freed_q        <= 1'b0;
			res_err_q          <= wsa_pkg::ERR_NONE;
			out_valid_q        <= 1'b0;
			granted_q          <= 1'b0;
			array_index_q      <= '0;
			token_given_q      <= '0;
			slot_freed_q       <= 1'b0;
			free_slots_total_q <= '0;
			error_code_q       <= wsa_pkg::ERR_NONE;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					wsa_pkg::REG_ARRAYS_IN_USE:   arrays_in_use_q   <= cfg_data[2:0];
					wsa_pkg::REG_SLOTS_PER_ARRAY: slots_per_array_q <= cfg_data[3:0];
					default: ;
				endcase
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						count_q       <= consumer_count;
						tok_q         <= tok_in;
						start_q       <= rr_q;
						grp_q         <= '0;
						res_granted_q <= 1'b0;
						res_arr_q     <= '0;
						res_tok_q     <= '0;
						res_freed_q   <= 1'b0;
						if (command == wsa_pkg::CMD_ALLOC) begin
							if (consumer_count == 8'd0) begin
								res_err_q <= wsa_pkg::ERR_ZERO_COUNT;
								state_q   <= ST_DONE;
							end else begin
								res_err_q <= wsa_pkg::ERR_NONE;
								state_q   <= ST_ALLOC;
							end
						end else begin
							if (tok_in_ok) begin
								res_err_q <= wsa_pkg::ERR_NONE;
								state_q   <= ST_REL;
							end else begin
								res_err_q <= wsa_pkg::ERR_BAD_TOKEN;
								state_q   <= ST_DONE;
							end
						end
					end
				end

				ST_ALLOC: begin
					if (!start_ok) begin
						// Pointer left over from a larger array count.
						start_q <= AW'(NW'(start_q) - NW'(n_act));
					end else if (!pick_found) begin
						// Every active array is full: stall.
						state_q <= ST_DONE;
					end else if (tok_hit) begin
						slots_used_q[pick]      <= slots_used_q[pick] + UW'(1);
						token_valid_q[free_tok] <= 1'b1;
						rr_q                    <= rr_next;
						res_granted_q           <= 1'b1;
						res_arr_q               <= pick;
						res_tok_q               <= free_tok;
						state_q                 <= ST_DONE;
					end else if (grp_last) begin
						// No free token: stall.
						state_q <= ST_DONE;
					end else begin
						grp_q <= grp_q + GIW'(1);
					end
				end

				ST_REL: begin
					res_arr_q <= rel_arr;
					if (rel_count_next == 8'd0) begin
						token_valid_q[tok_q] <= 1'b0;
						if (slots_used_q[rel_arr] != '0) begin
							slots_used_q[rel_arr] <= slots_used_q[rel_arr] - UW'(1);
						end
						res_freed_q <= 1'b1;
					end
					state_q <= ST_DONE;
				end

				ST_DONE: begin
					if (load_out) begin
						granted_q          <= res_granted_q;
						array_index_q      <= arr_out_ext[1:0];
						token_given_q      <= tok_out_ext[4:0];
						slot_freed_q       <= res_freed_q;
						free_slots_total_q <= free_sat;
						error_code_q       <= res_err_q;
						state_q            <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign cfg_ready        = 1'b1;
	assign in_ready         = (state_q == ST_IDLE);
	assign out_valid        = out_valid_q;
	assign granted          = granted_q;
	assign array_index      = array_index_q;
	assign token_given      = token_given_q;
	assign slot_freed       = slot_freed_q;
	assign free_slots_total = free_slots_total_q;
	assign error_code       = error_code_q;

endmodule

@@ tb/sv/tb_weight_slot_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_weight_slot_allocator
// Self-checking bench for the weight slot allocator. A ledger class keeps its
// own copy of the slot counts, the round-robin pointer and the token table.
// It works out the result word for every accepted request and checks each
// result word against the oldest one still awaited. The stimulus runs through
// several register settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_weight_slot_allocator;

	import wsa_pkg::*;

	// Register indexes above the two real registers. Writes to them must be
	// ignored by the block.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	localparam int PHASES        = 12;
	localparam int PHASE_WORDS   = 145;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 4;
	localparam int CYCLE_LIMIT   = 200000;

	// One result word of the block, field by field.
	typedef struct packed {
		logic       granted;
		logic [1:0] array_index;
		logic [4:0] token_given;
		logic       slot_freed;
		logic [5:0] free_total;
		logic [1:0] error;
	} slot_grant_t;

	// The ledger mirrors the allocator state. Requests are noted in the order
	// they are accepted, so the state here always matches what the block has
	// seen, and the stimulus may look at it to pick live tokens.
	class slot_ledger;
		logic [2:0]  array_cfg;
		logic [3:0]  depth_cfg;
		int          occupancy[NUM_ARRAYS_DEF];
		int          rr_next;
		bit          held[NUM_TOKENS_DEF];
		int          sharers[NUM_TOKENS_DEF];
		int          home_array[NUM_TOKENS_DEF];
		slot_grant_t awaited_grants[$];
		int unsigned faults;

		function new();
			array_cfg = ARRAYS_IN_USE_RST;
			depth_cfg = SLOTS_PER_ARRAY_RST;
			rr_next = 0;
			faults = 0;
			foreach (occupancy[i]) occupancy[i] = 0;
			foreach (held[i]) begin
				held[i] = 1'b0;
				sharers[i] = 0;
				home_array[i] = 0;
			end
		endfunction

		function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == REG_ARRAYS_IN_USE)
				array_cfg = data[2:0];
			else if (idx == REG_SLOTS_PER_ARRAY)
				depth_cfg = data;
		endfunction

		function int pending();
			return awaited_grants.size();
		endfunction

		function void note_request(logic cmd, logic [7:0] count, logic [4:0] tok);
			slot_grant_t want;
			int n, d, start, pick, spare, i, total, home;
			want = '0;
			// Both sizes are clamped; zero counts as one.
			n = (array_cfg == 0) ? 1 : (array_cfg > NUM_ARRAYS_DEF) ? NUM_ARRAYS_DEF : array_cfg;
			d = (depth_cfg == 0) ? 1 : (depth_cfg > MAX_SLOTS_DEF) ? MAX_SLOTS_DEF : depth_cfg;
			if (cmd == CMD_ALLOC) begin
				if (count == 0) begin
					want.error = ERR_ZERO_COUNT;
				end else begin
					// The pointer may be stale after a shrink of the array count.
					start = rr_next % n;
					pick = -1;
					spare = -1;
					for (i = 0; i < n; i++)
						if (pick < 0 && occupancy[(start + i) % n] < d)
							pick = (start + i) % n;
					for (i = 0; i < NUM_TOKENS_DEF; i++)
						if (spare < 0 && !held[i])
							spare = i;
					// Without a slot or a token this is a stall: nothing moves.
					if (pick >= 0 && spare >= 0) begin
						occupancy[pick]++;
						held[spare] = 1'b1;
						sharers[spare] = int'(count);
						home_array[spare] = pick;
						rr_next = (pick + 1) % n;
						want.granted = 1'b1;
						want.array_index = 2'(pick);
						want.token_given = 5'(spare);
					end
				end
			end else if (!held[tok]) begin
				want.error = ERR_BAD_TOKEN;
			end else begin
				home = home_array[tok];
				want.array_index = 2'(home);
				if (sharers[tok] > 0)
					sharers[tok]--;
				if (sharers[tok] == 0) begin
					held[tok] = 1'b0;
					if (occupancy[home] > 0)
						occupancy[home]--;
					want.slot_freed = 1'b1;
				end
			end
			// Arrays beyond the active count keep their slots but do not count.
			total = 0;
			for (i = 0; i < n; i++)
				if (occupancy[i] < d)
					total += d - occupancy[i];
			want.free_total = 6'((total > FREE_TOTAL_MAX) ? FREE_TOTAL_MAX : total);
			awaited_grants = {awaited_grants, want};
		endfunction

		function string fmt(slot_grant_t w);
			return $sformatf("grant %0d array %0d token %0d freed %0d free %0d err %0d",
				w.granted, w.array_index, w.token_given, w.slot_freed, w.free_total, w.error);
		endfunction

		function void check_result(slot_grant_t got);
			slot_grant_t want;
			if (awaited_grants.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("unexpected result word: %s", fmt(got));
			end else begin
				want = awaited_grants.pop_front();
				if (want.granted !== got.granted || want.array_index !== got.array_index ||
						want.token_given !== got.token_given ||
						want.slot_freed !== got.slot_freed ||
						want.free_total !== got.free_total || want.error !== got.error) begin
					faults++;
					if (faults <= 10)
						$display("result mismatch\n  expected: %s\n  actual:   %s",
							fmt(want), fmt(got));
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	logic       in_valid;
	logic       in_ready;
	logic       command;
	logic [7:0] consumer_count;
	logic [4:0] token_index;

	logic       out_valid;
	logic       out_ready;
	logic       granted;
	logic [1:0] array_index;
	logic [4:0] token_given;
	logic       slot_freed;
	logic [5:0] free_slots_total;
	logic [1:0] error_code;

	slot_ledger  ledger;
	slot_grant_t seen;
	bit          steady;
	bit          hold_request;
	int unsigned cycle_count;

	weight_slot_allocator dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.command          (command),
		.consumer_count   (consumer_count),
		.token_index      (token_index),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.granted          (granted),
		.array_index      (array_index),
		.token_given      (token_given),
		.slot_freed       (slot_freed),
		.free_slots_total (free_slots_total),
		.error_code       (error_code)
	);

	// 4 ns clock.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Watchdog: a run that hangs is a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[weight_slot_allocator] ERROR");
			$finish;
		end
	end

	// Result monitor. Outputs are sampled at the rising edge, where the
	// handshake takes effect.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
			seen.granted = granted;
			seen.array_index = array_index;
			seen.token_given = token_given;
			seen.slot_freed = slot_freed;
			seen.free_total = free_slots_total;
			seen.error = error_code;
			ledger.check_result(seen);
		end
	end

	// Result receiver. It drops ready at random except in a steady phase. When
	// asked, it holds ready low once for a long stretch so that the block backs
	// up and stalls the request channel while the sender keeps offering words.
	initial begin
		bit hold_done;
		hold_done = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request && !hold_done) begin
				hold_done = 1'b1;
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			out_ready = steady || ($urandom_range(0, 99) >= 31);
		end
	end

	// Offers one request word and returns at the falling edge after it was
	// taken. Valid stays high on return so that back-to-back words never show
	// a dip; a random gap lowers it before the next word goes out.
	task automatic send_request(input logic cmd, input logic [7:0] count, input logic [4:0] tok);
		while (!steady && $urandom_range(0, 99) < 31) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		command = cmd;
		consumer_count = count;
		token_index = tok;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		ledger.note_request(cmd, count, tok);
		@(negedge clk);
	endtask

	// Register writes go in only while the block is idle: every awaited word
	// has come back and a settling wait has let the pipeline drain.
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		in_valid = 1'b0;
		while (ledger.pending() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do
			@(posedge clk);
		while (cfg_ready !== 1'b1);
		ledger.apply_register(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	initial begin
		int live[$];
		int busiest, roll, pick, phase, w, t;
		logic [CFG_DATA_W-1:0] arrays_data, depth_data;
		logic       cmd;
		logic [7:0] cnt;
		logic [4:0] tok;

		ledger = new();
		steady = 1'b0;
		hold_request = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_ARRAYS_IN_USE;
		cfg_data = '0;
		in_valid = 1'b0;
		command = CMD_ALLOC;
		consumer_count = '0;
		token_index = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part at the reset setting of four arrays of eight slots.
		// A zero consumer count is an error, whatever the token field holds.
		send_request(CMD_ALLOC, 8'd0, 5'd31);
		// Releases of tokens that were never handed out.
		send_request(CMD_RELEASE, 8'd0, 5'd0);
		send_request(CMD_RELEASE, 8'd255, 5'd31);
		// Three grants walk the pointer over arrays 0, 1 and 2.
		send_request(CMD_ALLOC, 8'd255, 5'd0);
		send_request(CMD_ALLOC, 8'd1, 5'd0);
		send_request(CMD_ALLOC, 8'd1, 5'd0);
		// A release that frees its slot, then one that only lowers the count.
		send_request(CMD_RELEASE, 8'd0, 5'd1);
		send_request(CMD_RELEASE, 8'd0, 5'd0);

		// Two arrays of one slot: the pointer at 3 is now stale.
		write_register(REG_ARRAYS_IN_USE, 4'd2);
		write_register(REG_SLOTS_PER_ARRAY, 4'd1);
		send_request(CMD_ALLOC, 8'd3, 5'd0);
		// Both active arrays are full: a stall.
		send_request(CMD_ALLOC, 8'd1, 5'd0);
		// A token on an array beyond the active count still frees its slot.
		send_request(CMD_RELEASE, 8'd0, 5'd2);
		send_request(CMD_RELEASE, 8'd0, 5'd1);

		// Zero in both registers counts as one array of one slot.
		write_register(REG_ARRAYS_IN_USE, 4'd0);
		write_register(REG_SLOTS_PER_ARRAY, 4'd0);
		send_request(CMD_ALLOC, 8'd1, 5'd0);

		// Random part. The first phases pin the register extremes, including
		// values above the limits that must clamp; later phases draw them at
		// random. Writes to the unused indexes must change nothing.
		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin arrays_data = 4'd15; depth_data = 4'd15; end
				1: begin arrays_data = 4'd1;  depth_data = 4'd1;  end
				2: begin arrays_data = 4'd4;  depth_data = 4'd8;  end
				3: begin arrays_data = 4'd1;  depth_data = 4'd8;  end
				4: begin arrays_data = 4'd4;  depth_data = 4'd1;  end
				default: begin
					arrays_data = 4'($urandom_range(0, 15));
					depth_data = 4'($urandom_range(0, 15));
				end
			endcase
			write_register(REG_SPARE_A, 4'($urandom_range(0, 15)));
			write_register(REG_SPARE_B, 4'($urandom_range(0, 15)));
			write_register(REG_ARRAYS_IN_USE, arrays_data);
			write_register(REG_SLOTS_PER_ARRAY, depth_data);

			// One phase runs with no idling on either side; another starts
			// with a long stall of the receiver.
			steady = (phase == 2);
			if (phase == 5)
				hold_request = 1'b1;

			for (w = 0; w < PHASE_WORDS; w++) begin
				live.delete();
				busiest = -1;
				for (t = 0; t < NUM_TOKENS_DEF; t++)
					if (ledger.held[t]) begin
						live = {live, t};
						if (busiest < 0 || ledger.sharers[t] > ledger.sharers[busiest])
							busiest = t;
					end
				roll = $urandom_range(0, 99);
				cnt = 8'($urandom);
				tok = 5'($urandom);
				if (roll < 45 || (live.size() == 0 && roll < 90)) begin
					// Allocate, mostly with a few sharers so that tokens cycle.
					// Now and then a zero count or a large one.
					cmd = CMD_ALLOC;
					pick = $urandom_range(0, 199);
					if (pick < 8)
						cnt = 8'd0;
					else if (pick == 8)
						cnt = 8'($urandom_range(1, 255));
					else
						cnt = 8'($urandom_range(1, 3));
				end else if (roll < 90) begin
					// Release a live token. When the one with the most sharers holds
					// more than three, half the time it is drained, so large counts do not pin slots.
					cmd = CMD_RELEASE;
					if (ledger.sharers[busiest] > 3 && $urandom_range(0, 1) == 1)
						tok = 5'(busiest);
					else
						tok = 5'(live[$urandom_range(0, live.size() - 1)]);
				end else begin
					// Noise: a release of any token, live or not.
					cmd = CMD_RELEASE;
				end
				send_request(cmd, cnt, tok);
			end
		end

		in_valid = 1'b0;
		steady = 1'b0;
		while (ledger.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (ledger.faults == 0)
			$display("[weight_slot_allocator] OK");
		else
			$display("[weight_slot_allocator] ERROR");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/wsa_pkg.sv
hw/rtl/wsa_ram.sv
hw/rtl/weight_slot_allocator.sv
tb/sv/tb_weight_slot_allocator.sv
